FILE: src/qcnt_pkg.sv
// qcnt_pkg: shared types, constants and the quadrature step table
// for the multi-channel quadrature counter; no dependencies
package qcnt_pkg;

  localparam int PHASES     = 6;   // phase bits carried by one sample request
  localparam int OUT_FIELDS = 6;   // count fields on the result channel
  localparam int CNT_W      = 16;
  localparam int IDX_W      = 3;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_SET    = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic [PHASES-1:0]         chan_a;
    logic [PHASES-1:0]         chan_b;
    logic [IDX_W-1:0]          motor_index;
    logic signed [CNT_W-1:0]   set_value;
  } req_t;

  typedef logic [OUT_FIELDS-1:0][CNT_W-1:0] cnt_bus_t;

  // code is {old b, old a, new b, new a}; result is a 2-bit two's complement step
  function automatic logic [1:0] step_of(input logic [3:0] code);
    logic [1:0] s;
    unique case (code)
      4'h1, 4'h7, 4'h8, 4'hE: s = 2'b11;
      4'h2, 4'h4, 4'hB, 4'hD: s = 2'b01;
      default:                s = 2'b00;
    endcase
    return s;
  endfunction

endpackage

FILE: src/multi_channel_quadrature_counter_core.sv
// multi_channel_quadrature_counter_core: top level, request register, count bank
// and result register; depends on qcnt_pkg and qcnt_counts

// Takes one request per clock when the result side is not stalling and returns
// one result per request, through the request register and then the result
// register. A sample request decodes every channel's old and new (B,A) pair
// through a fixed table into a step of +1, -1 or 0 (double transitions count 0)
// and adds it to that channel's wrapping 16-bit count; the first sample after
// reset only primes the history. A set request loads one channel's count and
// leaves the history alone; an index at or above NUM_ENCODERS is ignored. Each
// result carries all six counts, with fields at or above NUM_ENCODERS held at
// zero. The throughput of one request per cycle is set by the combinational
// count update between the request register and the result register.
module multi_channel_quadrature_counter_core #(
  parameter int NUM_ENCODERS = 6
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_opcode,
  input  logic [qcnt_pkg::PHASES-1:0]            in_chan_a,
  input  logic [qcnt_pkg::PHASES-1:0]            in_chan_b,
  input  logic [qcnt_pkg::IDX_W-1:0]             in_motor_index,
  input  logic signed [qcnt_pkg::CNT_W-1:0]      in_set_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [qcnt_pkg::CNT_W-1:0]      out_count_0,
  output logic signed [qcnt_pkg::CNT_W-1:0]      out_count_1,
  output logic signed [qcnt_pkg::CNT_W-1:0]      out_count_2,
  output logic signed [qcnt_pkg::CNT_W-1:0]      out_count_3,
  output logic signed [qcnt_pkg::CNT_W-1:0]      out_count_4,
  output logic signed [qcnt_pkg::CNT_W-1:0]      out_count_5
);

  qcnt_pkg::req_t     req_r;
  logic               req_valid_r, req_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  qcnt_pkg::cnt_bus_t out_cnt_r, cnt_nxt;
  logic               accept, advance;

  // request stage moves on when the result register is free or being drained
  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (accept) begin
      req_valid_nxt = 1'b1;
    end else if (advance) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  qcnt_counts #(
    .NUM_ENCODERS(NUM_ENCODERS)
  ) u_counts (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (advance),
    .req    (req_r),
    .cnt_nxt(cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.opcode      <= qcnt_pkg::opcode_t'(in_opcode);
      req_r.chan_a      <= in_chan_a;
      req_r.chan_b      <= in_chan_b;
      req_r.motor_index <= in_motor_index;
      req_r.set_value   <= in_set_value;
    end
    if (advance) begin
      out_cnt_r <= cnt_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_count_0 = out_cnt_r[0];
  assign out_count_1 = out_cnt_r[1];
  assign out_count_2 = out_cnt_r[2];
  assign out_count_3 = out_cnt_r[3];
  assign out_count_4 = out_cnt_r[4];
  assign out_count_5 = out_cnt_r[5];

endmodule

FILE: src/qcnt_decode.sv
// qcnt_decode: per-channel quadrature step decode from old and new phase pairs
// depends on qcnt_pkg
module qcnt_decode #(
  parameter int NUM_ENCODERS = 6
) (
  input  logic [qcnt_pkg::PHASES-1:0] prev_a,
  input  logic [qcnt_pkg::PHASES-1:0] prev_b,
  input  logic [qcnt_pkg::PHASES-1:0] now_a,
  input  logic [qcnt_pkg::PHASES-1:0] now_b,
  output logic [NUM_ENCODERS-1:0][1:0] step
);

  for (genvar ch = 0; ch < NUM_ENCODERS; ch++) begin : g_ch
    if (ch < qcnt_pkg::PHASES) begin : g_live
      assign step[ch] = qcnt_pkg::step_of({prev_b[ch], prev_a[ch], now_b[ch], now_a[ch]});
    end else begin : g_dead
      // no phase pins for this channel, it never moves
      assign step[ch] = 2'b00;
    end
  end

endmodule

FILE: src/qcnt_counts.sv
// qcnt_counts: sample history and per-channel position count registers
// depends on qcnt_pkg and qcnt_decode
module qcnt_counts #(
  parameter int NUM_ENCODERS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  qcnt_pkg::req_t     req,
  output qcnt_pkg::cnt_bus_t cnt_nxt
);

  localparam int CW = qcnt_pkg::CNT_W;

  logic [qcnt_pkg::PHASES-1:0]     prev_a_r, prev_b_r;
  logic                            seen_r;
  logic [NUM_ENCODERS-1:0][CW-1:0] counts_r, counts_nxt;
  logic [NUM_ENCODERS-1:0][1:0]    step;
  logic                            is_sample;

  assign is_sample = (req.opcode == qcnt_pkg::OP_SAMPLE);

  qcnt_decode #(
    .NUM_ENCODERS(NUM_ENCODERS)
  ) u_decode (
    .prev_a(prev_a_r),
    .prev_b(prev_b_r),
    .now_a (req.chan_a),
    .now_b (req.chan_b),
    .step  (step)
  );

  for (genvar ch = 0; ch < NUM_ENCODERS; ch++) begin : g_cnt
    always_comb begin
      counts_nxt[ch] = counts_r[ch];
      if (upd) begin
        if (is_sample) begin
          if (seen_r) begin
            counts_nxt[ch] = counts_r[ch] + {{(CW-2){step[ch][1]}}, step[ch]};
          end
        end else if (req.motor_index == qcnt_pkg::IDX_W'(ch)) begin
          counts_nxt[ch] = req.set_value;
        end
      end
    end
  end

  for (genvar k = 0; k < qcnt_pkg::OUT_FIELDS; k++) begin : g_out
    if (k < NUM_ENCODERS) begin : g_used
      assign cnt_nxt[k] = counts_nxt[k];
    end else begin : g_unused
      assign cnt_nxt[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= '0;
      prev_b_r <= '0;
      seen_r   <= 1'b0;
      counts_r <= '0;
    end else begin
      counts_r <= counts_nxt;
      if (upd && is_sample) begin
        prev_a_r <= req.chan_a;
        prev_b_r <= req.chan_b;
        seen_r   <= 1'b1;
      end
    end
  end

  // first sample after reset only primes the history
  a_first_sample_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    upd && is_sample && !seen_r |=> $stable(counts_r))
    else $error("counts moved on the priming sample");

  a_sample_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
    upd && is_sample |=> seen_r)
    else $error("sample history not marked after a sample");

  a_set_keeps_history: assert property (@(posedge clk) disable iff (!rst_n)
    upd && !is_sample |=> $stable(prev_a_r) && $stable(prev_b_r) && $stable(seen_r))
    else $error("set request disturbed the sample history");

  a_idle_holds_counts: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(counts_r))
    else $error("counts changed with no request");

endmodule

FILE: tb/multi_channel_quadrature_counter_core_tb.sv
// testbench for multi_channel_quadrature_counter_core: directed rows, then random
// quadrature walks checked against a position tracker; depends on qcnt_pkg and the rtl
module multi_channel_quadrature_counter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENCODERS = 6;
  localparam int N_RANDOM = 1500;
  localparam int DIR_ROWS = 24;

  typedef logic [0:qcnt_pkg::OUT_FIELDS-1][qcnt_pkg::CNT_W-1:0] counts_t;

  typedef struct packed {
    qcnt_pkg::opcode_t                 op;
    logic [qcnt_pkg::PHASES-1:0]       a;
    logic [qcnt_pkg::PHASES-1:0]       b;
    logic [qcnt_pkg::IDX_W-1:0]        idx;
    logic [qcnt_pkg::CNT_W-1:0]        val;
    logic                              chk;
    counts_t                           want;
  } stim_row_t;

  localparam logic [qcnt_pkg::CNT_W-1:0] TOP    = 16'h7FFF;
  localparam logic [qcnt_pkg::CNT_W-1:0] BOTTOM = 16'h8000;

  // step per {old b, old a, new b, new a}
  localparam int QUAD_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // first sample only primes the history; index and value are ignored
    '{qcnt_pkg::OP_SAMPLE, 6'h15, 6'h2A, 3'd7, BOTTOM, 1'b1, '0},
    '{qcnt_pkg::OP_SET, 6'h3F, 6'h3F, 3'd0, TOP, 1'b1,
      '{TOP, '0, '0, '0, '0, '0}},
    '{qcnt_pkg::OP_SET, 6'h00, 6'h00, 3'd5, BOTTOM, 1'b1,
      '{TOP, '0, '0, '0, '0, BOTTOM}},
    // out-of-range index leaves every count alone
    '{qcnt_pkg::OP_SET, 6'h15, 6'h2A, 3'd6, 16'h1234, 1'b1,
      '{TOP, '0, '0, '0, '0, BOTTOM}},
    '{qcnt_pkg::OP_SET, 6'h2A, 6'h15, 3'd7, 16'hFFFF, 1'b1,
      '{TOP, '0, '0, '0, '0, BOTTOM}},
    // channel 0 steps up through the positive limit, channel 5 down through the negative
    '{qcnt_pkg::OP_SAMPLE, 6'h14, 6'h2A, 3'd0, 16'h0000, 1'b1,
      '{BOTTOM, '0, '0, '0, '0, BOTTOM}},
    '{qcnt_pkg::OP_SAMPLE, 6'h14, 6'h0A, 3'd0, 16'h0000, 1'b1,
      '{BOTTOM, '0, '0, '0, '0, TOP}},
    '{qcnt_pkg::OP_SAMPLE, 6'h00, 6'h00, 3'd1, 16'h5555, 1'b0, '0},
    // double transitions and no change
    '{qcnt_pkg::OP_SAMPLE, 6'h3F, 6'h3F, 3'd5, TOP, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h00, 6'h00, 3'd2, BOTTOM, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h00, 6'h00, 3'd0, 16'h0000, 1'b0, '0},
    // one full cycle backward on every channel
    '{qcnt_pkg::OP_SAMPLE, 6'h3F, 6'h00, 3'd0, 16'h0000, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h3F, 6'h3F, 3'd0, 16'h0000, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h00, 6'h3F, 3'd0, 16'h0000, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h00, 6'h00, 3'd0, 16'h0000, 1'b0, '0},
    // and one forward
    '{qcnt_pkg::OP_SAMPLE, 6'h00, 6'h3F, 3'd0, 16'h0000, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h3F, 6'h3F, 3'd0, 16'h0000, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h3F, 6'h00, 3'd0, 16'h0000, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h00, 6'h00, 3'd0, 16'h0000, 1'b0, '0},
    '{qcnt_pkg::OP_SET, 6'h00, 6'h00, 3'd3, 16'h0001, 1'b0, '0},
    '{qcnt_pkg::OP_SET, 6'h3F, 6'h3F, 3'd2, 16'hFFFF, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h3F, 6'h00, 3'd4, 16'hAAAA, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h00, 6'h3F, 3'd6, 16'h0F0F, 1'b0, '0},
    '{qcnt_pkg::OP_SAMPLE, 6'h2A, 6'h15, 3'd3, 16'hF0F0, 1'b0, '0}
  };

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic                              in_opcode;
  logic [qcnt_pkg::PHASES-1:0]       in_chan_a;
  logic [qcnt_pkg::PHASES-1:0]       in_chan_b;
  logic [qcnt_pkg::IDX_W-1:0]        in_motor_index;
  logic signed [qcnt_pkg::CNT_W-1:0] in_set_value;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [qcnt_pkg::CNT_W-1:0] out_count_0;
  logic signed [qcnt_pkg::CNT_W-1:0] out_count_1;
  logic signed [qcnt_pkg::CNT_W-1:0] out_count_2;
  logic signed [qcnt_pkg::CNT_W-1:0] out_count_3;
  logic signed [qcnt_pkg::CNT_W-1:0] out_count_4;
  logic signed [qcnt_pkg::CNT_W-1:0] out_count_5;

  // tracker state
  logic [qcnt_pkg::PHASES-1:0] hist_a;
  logic [qcnt_pkg::PHASES-1:0] hist_b;
  logic                        hist_valid;
  logic [qcnt_pkg::CNT_W-1:0]  position [qcnt_pkg::OUT_FIELDS];

  counts_t expected_counts [$];

  bit gaps_on;
  bit stall_on;
  int n_errors;
  int n_results;
  int n_samples;
  int n_sets;
  int n_sets_ignored;

  multi_channel_quadrature_counter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_chan_a      (in_chan_a),
    .in_chan_b      (in_chan_b),
    .in_motor_index (in_motor_index),
    .in_set_value   (in_set_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_count_0    (out_count_0),
    .out_count_1    (out_count_1),
    .out_count_2    (out_count_2),
    .out_count_3    (out_count_3),
    .out_count_4    (out_count_4),
    .out_count_5    (out_count_5)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // advances the tracked counts by one request and returns the counts it reports
  function automatic counts_t track_position(input qcnt_pkg::opcode_t op,
                                             input logic [qcnt_pkg::PHASES-1:0] a,
                                             input logic [qcnt_pkg::PHASES-1:0] b,
                                             input logic [qcnt_pkg::IDX_W-1:0] idx,
                                             input logic [qcnt_pkg::CNT_W-1:0] val);
    counts_t res;
    logic [3:0] code;
    if (op == qcnt_pkg::OP_SAMPLE) begin
      if (hist_valid) begin
        for (int ch = 0; ch < ENCODERS; ch++) begin
          code = {hist_b[ch], hist_a[ch], b[ch], a[ch]};
          position[ch] = position[ch] + 16'(QUAD_STEP[code]);
        end
      end
      hist_a = a;
      hist_b = b;
      hist_valid = 1'b1;
    end else if (idx < ENCODERS) begin
      position[idx] = val;
    end
    for (int ch = 0; ch < qcnt_pkg::OUT_FIELDS; ch++)
      res[ch] = (ch < ENCODERS) ? position[ch] : '0;
    return res;
  endfunction

  // one quadrature move of a (B,A) pair: hold, forward, back or an illegal jump
  function automatic logic [1:0] move_pair(input logic [1:0] p);
    logic [1:0] k;
    int r;
    k = {p[1], p[1] ^ p[0]};
    r = $urandom_range(0, 15);
    if (r < 6) return p;
    if (r < 10) k = k + 2'd1;
    else if (r < 14) k = k - 2'd1;
    else return p ^ 2'b11;
    return {k[1], k[1] ^ k[0]};
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input qcnt_pkg::opcode_t op,
                              input logic [qcnt_pkg::PHASES-1:0] a,
                              input logic [qcnt_pkg::PHASES-1:0] b,
                              input logic [qcnt_pkg::IDX_W-1:0] idx,
                              input logic [qcnt_pkg::CNT_W-1:0] val, input logic chk,
                              input counts_t want);
    int gap;
    counts_t pred;
    gap = gaps_on ? idle_cycles() : 0;
    if (gap > 0) begin
      in_valid       <= 1'b0;
      in_opcode      <= 1'($urandom);
      in_chan_a      <= 6'($urandom);
      in_chan_b      <= 6'($urandom);
      in_motor_index <= 3'($urandom);
      in_set_value   <= 16'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_chan_a      <= a;
    in_chan_b      <= b;
    in_motor_index <= idx;
    in_set_value   <= val;
    do @(posedge clk); while (in_stall);
    pred = track_position(op, a, b, idx, val);
    expected_counts.push_back(chk ? want : pred);
    if (op == qcnt_pkg::OP_SAMPLE) n_samples++;
    else begin
      n_sets++;
      if (idx >= ENCODERS) n_sets_ignored++;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_on) begin
        out_stall <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        hold = idle_cycles();
      end
    end
  end

  always @(posedge clk) begin : check_results
    counts_t got;
    counts_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_count_0, out_count_1, out_count_2, out_count_3, out_count_4, out_count_5};
      if (expected_counts.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_counts.pop_front();
        for (int ch = 0; ch < qcnt_pkg::OUT_FIELDS; ch++) begin
          if (got[ch] !== want[ch])
            report_mismatch($sformatf("count_%0d got %0d expected %0d", ch,
                                      $signed(got[ch]), $signed(want[ch])));
        end
      end
      n_results++;
    end
  end

  initial begin
    logic [qcnt_pkg::PHASES-1:0] na;
    logic [qcnt_pkg::PHASES-1:0] nb;
    logic [1:0]                  pr;
    logic [qcnt_pkg::CNT_W-1:0]  v;
    int r;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = qcnt_pkg::OP_SAMPLE;
    in_chan_a      = '0;
    in_chan_b      = '0;
    in_motor_index = '0;
    in_set_value   = '0;
    hist_a         = '0;
    hist_b         = '0;
    hist_valid     = 1'b0;
    for (int ch = 0; ch < qcnt_pkg::OUT_FIELDS; ch++) position[ch] = '0;
    gaps_on        = 1'b1;
    stall_on       = 1'b1;
    n_errors       = 0;
    n_results      = 0;
    n_samples      = 0;
    n_sets         = 0;
    n_sets_ignored = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_request(DIRECTED[i].op, DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].idx,
                   DIRECTED[i].val, DIRECTED[i].chk, DIRECTED[i].want);
    wait_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      // a stretch with no idling on either side
      gaps_on  = !(i >= 600 && i < 800);
      stall_on = gaps_on;
      if (i == 1000) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 7) begin
        case ($urandom_range(0, 5))
          0: v = TOP;
          1: v = BOTTOM;
          2: v = TOP - 16'($urandom_range(0, 3));
          3: v = BOTTOM + 16'($urandom_range(0, 3));
          default: v = 16'($urandom);
        endcase
        send_request(qcnt_pkg::OP_SET, 6'($urandom), 6'($urandom),
                     3'($urandom_range(0, 7)), v, 1'b0, '0);
      end else if (r < 12) begin
        // noise: arbitrary phase jumps
        send_request(qcnt_pkg::OP_SAMPLE, 6'($urandom), 6'($urandom), 3'($urandom),
                     16'($urandom), 1'b0, '0);
      end else begin
        for (int ch = 0; ch < qcnt_pkg::PHASES; ch++) begin
          pr = move_pair({hist_b[ch], hist_a[ch]});
          nb[ch] = pr[1];
          na[ch] = pr[0];
        end
        send_request(qcnt_pkg::OP_SAMPLE, na, nb, 3'($urandom), 16'($urandom), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d sample and %0d set requests (%0d set with an out-of-range index),",
             n_samples, n_sets, n_sets_ignored);
    $display("%0d results compared, %0d mismatching fields", n_results, n_errors);
    if (n_errors == 0 && expected_counts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timed out with %0d results outstanding", expected_counts.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
